>>> sv/ttc_pkg.sv
// ----------------------------------------------------------------------------
// ttc_pkg
// Shared types and constants for the text console teletype engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ttc_pkg;

    // payload widths of the stream fields
    localparam int REQ_W  = 3;
    localparam int CHAR_W = 8;
    localparam int POS_W  = 16;
    localparam int ADDR_W = 14;
    localparam int CELL_W = 16;
    localparam int COLOR_W = 8;

    // blank cell: char 0, light gray on black
    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
    localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h07;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;

    // configuration register indexes
    localparam logic CFG_TEXT_COLOR = 1'b0;
    localparam logic CFG_PAGE_BASE  = 1'b1;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE   = 3'd0,
        REQ_READ    = 3'd1,
        REQ_SCR_UP  = 3'd2,
        REQ_SCR_DN  = 3'd3,
        REQ_CLEAR   = 3'd4,
        REQ_SET_POS = 3'd5
    } t_req;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SHIFT_UP,
        ST_SHIFT_DN,
        ST_DIV,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> sv/ttc_cell_ram.sv
// ----------------------------------------------------------------------------
// ttc_cell_ram
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_cell_ram
    import ttc_pkg::*;
#(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [CELL_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

>>> sv/ttc_pos_div.sv
// ----------------------------------------------------------------------------
// ttc_pos_div
// Constant divider: linear position into row and column.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_pos_div
    import ttc_pkg::*;
#(
    parameter int COLUMNS = 80
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [POS_W-1:0]             i_dividend,
    output logic                              o_done,
    output logic      [POS_W-1:0]             o_quotient,
    output logic      [$clog2(COLUMNS)-1:0]   o_remainder
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int SHIFT = POS_W + CW;
    localparam int MW    = POS_W + 2;
    localparam int PW    = POS_W + MW;

    // rounded-up reciprocal, exact for every dividend of POS_W bits
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(COLUMNS) - 1)
                                 / longint'(COLUMNS);
    localparam logic [MW-1:0]    RECIP = MW'(RECIP_L);
    localparam logic [POS_W-1:0] COLS  = POS_W'(COLUMNS);

    logic                 r_stage;
    logic                 r_done;
    logic [POS_W-1:0]     r_dvd;
    logic [POS_W-1:0]     r_q;
    logic [CW-1:0]        r_rem;

    logic [PW-1:0]        prod;
    logic [POS_W-1:0]     q_times_c;

    // quotient by reciprocal multiplication, then remainder by subtraction
    assign prod      = PW'(i_dividend) * PW'(RECIP);
    assign q_times_c = r_q * COLS;

    // control: the quotient is registered first, then the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= POS_W'(prod >> SHIFT);
            r_dvd <= i_dividend;
        end
        if (r_stage) begin
            r_rem <= CW'(r_dvd - q_times_c);
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_q;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> sv/text_console_teletype.sv
// ----------------------------------------------------------------------------
// text_console_teletype
// Text-mode console engine with a cell store, cursor and scrolling.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis stream (kind in tuser, char and position in
// tdata); each request gives exactly one result on m_axis (read char and
// cursor address in tdata, bad-request flag in tuser). Color and page base
// are written through the plain cfg port; the user is to write them only
// while the block is idle, and the block itself does not enforce it.
// The cell store has one read and one write port; scrolls, and writes or
// reads that push the cursor past the last row, stream through it one cell
// a cycle, and that port sets the cost of full-screen work. A new request
// is taken only in the idle state, once the last result has gone into the
// output register. Reset blanks the whole store with s_axis_tready low.
// One result register sits on the output: while it is stalled a new
// request is still taken, and its result waits until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_teletype
    import ttc_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // char_code[7:0], position[23:8]
    input  wire logic [2:0]  s_axis_tuser,   // req_type[2:0]
    // results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,   // read_char[7:0], cursor_addr[21:8]
    output logic      [0:0]  m_axis_tuser,   // bad_request[0]
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [13:0] i_cfg_wdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int IW = $clog2(CELLS);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int NW = $clog2(CELLS + 1);

    localparam logic [IW-1:0] ROW_STEP      = IW'(COLUMNS);
    localparam logic [IW-1:0] LAST_ROW_BASE = IW'((ROWS - 1) * COLUMNS);
    localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
    localparam logic [NW-1:0] N_CELLS       = NW'(CELLS);
    localparam logic [NW-1:0] N_LAST        = NW'(CELLS - 1);
    localparam logic [NW-1:0] N_MOVE        = NW'(CELLS - COLUMNS);
    localparam logic [NW-1:0] N_ROW         = NW'(COLUMNS);

    // state
    t_state              r_state, n_state;
    logic                r_boot, n_boot;
    logic [NW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [IW-1:0]       r_idx, n_idx;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [CHAR_W-1:0]   r_rd, n_rd;
    logic                r_bad, n_bad;
    logic [COLOR_W-1:0]  r_color;
    logic [ADDR_W-1:0]   r_page;

    // result register
    logic                r_out_valid;
    logic [CHAR_W-1:0]   r_out_char;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_bad;
    logic                load_out;

    // cell store ports
    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [IW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    // divider
    logic                div_start;
    logic                div_done;
    logic [POS_W-1:0]    div_quo;
    logic [CW-1:0]       div_rem;

    // cursor advance
    logic                adv_wrap;
    logic                adv_scroll;
    logic [CW-1:0]       adv_col;
    logic [RW-1:0]       adv_row;
    logic [IW-1:0]       adv_idx;

    logic                req_valid;
    logic [CHAR_W-1:0]   in_char;
    logic                pos_clamp;

    ttc_cell_ram #(
        .DEPTH (CELLS),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ttc_pos_div #(
        .COLUMNS (COLUMNS)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (s_axis_tdata[23:8]),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign in_char   = s_axis_tdata[7:0];
    assign req_valid = s_axis_tvalid && (r_state == ST_IDLE);
    assign pos_clamp = (div_quo > POS_W'(ROWS - 1));

    // next cursor after one step forward
    always_comb begin
        adv_wrap   = (r_col == LAST_COL);
        adv_scroll = adv_wrap && (r_row == LAST_ROW);
        adv_col    = adv_wrap ? '0 : r_col + 1'b1;
        adv_row    = (adv_wrap && !adv_scroll) ? r_row + 1'b1 : r_row;
        adv_idx    = adv_scroll ? LAST_ROW_BASE : r_idx + 1'b1;
    end

    // next state and store access
    always_comb begin
        n_state   = r_state;
        n_boot    = r_boot;
        n_cnt     = r_cnt;
        n_col     = r_col;
        n_row     = r_row;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_rd      = r_rd;
        n_bad     = r_bad;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        div_start = 1'b0;
        load_out  = 1'b0;

        unique case (r_state)
            // blank every cell, after reset or for a clear request
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_cnt);
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == N_LAST) begin
                    n_cnt   = '0;
                    n_boot  = 1'b0;
                    n_state = r_boot ? ST_IDLE : ST_FINISH;
                end
            end

            ST_IDLE: begin
                if (req_valid) begin
                    n_rd  = '0;
                    n_bad = 1'b0;
                    n_cnt = '0;
                    n_pos = s_axis_tdata[23:8];
                    unique case (s_axis_tuser)
                        REQ_WRITE: begin
                            n_state = ST_FINISH;
                            if (in_char == CH_NEWLINE) begin
                                ram_we = 1'b1;
                                n_col  = '0;
                                if (r_row == LAST_ROW) begin
                                    n_idx   = LAST_ROW_BASE;
                                    n_state = ST_SHIFT_UP;
                                end else begin
                                    n_row = r_row + 1'b1;
                                    n_idx = r_idx - IW'(r_col) + ROW_STEP;
                                end
                            end else if (in_char == CH_BACKSPACE) begin
                                if (r_col != '0 || r_row != '0) begin
                                    ram_we    = 1'b1;
                                    ram_waddr = r_idx - 1'b1;
                                    n_idx     = r_idx - 1'b1;
                                    if (r_col == '0) begin
                                        n_col = LAST_COL;
                                        n_row = r_row - 1'b1;
                                    end else begin
                                        n_col = r_col - 1'b1;
                                    end
                                end
                            end else if (in_char != CH_RETURN) begin
                                ram_we    = 1'b1;
                                ram_wdata = {r_color, in_char};
                                n_col     = adv_col;
                                n_row     = adv_row;
                                n_idx     = adv_idx;
                                if (adv_scroll) begin
                                    n_state = ST_SHIFT_UP;
                                end
                            end
                        end
                        REQ_READ: begin
                            ram_re  = 1'b1;
                            n_state = ST_READ;
                        end
                        REQ_SCR_UP: begin
                            n_state = ST_SHIFT_DN;
                        end
                        REQ_SCR_DN: begin
                            n_state = ST_SHIFT_UP;
                            if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_idx = r_idx - ROW_STEP;
                            end
                        end
                        REQ_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_col   = '0;
                            n_row   = '0;
                            n_idx   = '0;
                        end
                        REQ_SET_POS: begin
                            div_start = 1'b1;
                            n_state   = ST_DIV;
                        end
                        default: begin
                            n_bad   = 1'b1;
                            n_state = ST_FINISH;
                        end
                    endcase
                end
            end

            // read data arrives, then the cursor steps forward
            ST_READ: begin
                n_rd    = ram_rdata[7:0];
                n_col   = adv_col;
                n_row   = adv_row;
                n_idx   = adv_idx;
                n_state = adv_scroll ? ST_SHIFT_UP : ST_FINISH;
            end

            // rows move toward row 0, last row blanked; reads run one row ahead
            ST_SHIFT_UP: begin
                ram_re    = (r_cnt < N_MOVE);
                ram_raddr = IW'(r_cnt + N_ROW);
                ram_we    = (r_cnt != '0);
                ram_waddr = IW'(r_cnt - 1'b1);
                ram_wdata = (r_cnt > N_MOVE) ? BLANK_CELL : ram_rdata;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == N_CELLS) begin
                    n_cnt   = '0;
                    n_state = ST_FINISH;
                end
            end

            // rows move away from row 0, row 0 blanked; sweep from the last cell
            ST_SHIFT_DN: begin
                ram_re    = (r_cnt < N_MOVE);
                ram_raddr = IW'(N_MOVE - 1'b1 - r_cnt);
                ram_we    = (r_cnt != '0);
                ram_waddr = IW'(N_CELLS - r_cnt);
                ram_wdata = (r_cnt > N_MOVE) ? BLANK_CELL : ram_rdata;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == N_CELLS) begin
                    n_cnt   = '0;
                    n_state = ST_FINISH;
                end
            end

            // row saturates at the last row, column taken from the remainder
            ST_DIV: begin
                if (div_done) begin
                    n_col   = div_rem;
                    n_row   = pos_clamp ? LAST_ROW : RW'(div_quo);
                    n_idx   = pos_clamp ? LAST_ROW_BASE + IW'(div_rem) : IW'(r_pos);
                    n_state = ST_FINISH;
                end
            end

            // hand the result to the output register once it is free
            ST_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_boot  <= 1'b1;
            r_cnt   <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_row   <= n_row;
            r_idx   <= n_idx;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_rd  <= n_rd;
        r_bad <= n_bad;
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= COLOR_RESET;
            r_page  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEXT_COLOR: r_color <= i_cfg_wdata[7:0];
                CFG_PAGE_BASE:  r_page  <= i_cfg_wdata;
                default:        r_page  <= r_page;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_char <= r_rd;
            r_out_addr <= r_page + ADDR_W'(r_idx);
            r_out_bad  <= r_bad;
        end
    end

    assign s_axis_tready   = (r_state == ST_IDLE);
    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tdata    = {2'b00, r_out_addr, r_out_char};
    assign m_axis_tuser[0] = r_out_bad;

endmodule

`default_nettype wire

>>> sv/ttc_checker.sv
// ----------------------------------------------------------------------------
// ttc_checker
// Port-level checks for the text console teletype, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // store is being blanked right after reset
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("request taken during reset clearing pass");

    // one request at a time
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken back to back");

    // a bad request never returns a character
    a_bad_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00)
        else $error("bad request carries a read character");

endmodule

bind text_console_teletype ttc_checker u_ttc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> tb/text_console_teletype_tb.sv
// ----------------------------------------------------------------------------
// text_console_teletype_tb
// Self-checking bench for the text console engine: a short table of directed
// requests (cursor edges, control characters, scrolls, bad kinds) and then
// three random phases under different color and page settings. A behavioral
// model of the screen and cursor predicts every result, and each transfer is
// compared field by field with the oldest expectation (table value if fixed).
// ----------------------------------------------------------------------------
module text_console_teletype_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ttc_pkg::*;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int PAGE_MAX    = 14000;

    // request kinds outside the known set
    localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
    } console_req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] read_char;
        logic [ADDR_W-1:0] cursor_addr;
        logic              bad_request;
    } console_result_t;

    // one stimulus row; want_* only count when fixed is set
    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  pos;
        logic              fixed;
        logic [CHAR_W-1:0] want_char;
        logic [ADDR_W-1:0] want_addr;
        logic              want_bad;
    } directed_row_t;

    localparam int DIRECTED_COUNT = 26;
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{REQ_READ,    8'h00,        16'd0,     1'b1, 8'h00, 14'd1,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'd0,     1'b1, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   8'h41,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   8'hFF,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   8'h00,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_RETURN,    16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_BACKSPACE, 16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'd0,     1'b1, 8'h00, 14'd0,    1'b0},
        '{REQ_READ,    8'h00,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_BACKSPACE, 16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_BACKSPACE, 16'd0,     1'b1, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_NEWLINE,   16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'd79,    1'b1, 8'h00, 14'd79,   1'b0},
        '{REQ_WRITE,   8'h7E,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_BACKSPACE, 16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'hFFFF,  1'b1, 8'h00, 14'd1935, 1'b0},
        '{REQ_SET_POS, 8'h00,        16'd1999,  1'b1, 8'h00, 14'd1999, 1'b0},
        '{REQ_WRITE,   8'h5A,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'd1999,  1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_WRITE,   CH_NEWLINE,   16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SCR_UP,  8'h00,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SET_POS, 8'h00,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_SCR_DN,  8'h00,        16'd0,     1'b0, 8'h00, 14'd0,    1'b0},
        '{REQ_CLEAR,   8'h00,        16'd0,     1'b1, 8'h00, 14'd0,    1'b0},
        '{REQ_BAD_LO,  8'h00,        16'd0,     1'b1, 8'h00, 14'd0,    1'b1},
        '{REQ_BAD_HI,  8'hFF,        16'hFFFF,  1'b1, 8'h00, 14'd0,    1'b1}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [23:0]       s_axis_tdata = '0;  // char_code[7:0], position[23:8]
    logic [2:0]        s_axis_tuser = '0;  // req_type[2:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [23:0]       m_axis_tdata;       // read_char[7:0], cursor_addr[21:8]
    logic [0:0]        m_axis_tuser;       // bad_request[0]
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_index = '0;
    logic [13:0]       i_cfg_wdata = '0;

    // screen and cursor as the block should hold them
    logic [CELL_W-1:0]  screen_cells [CELL_COUNT];
    int unsigned        cur_col;
    int unsigned        cur_row;
    logic [COLOR_W-1:0] color_reg;
    logic [ADDR_W-1:0]  base_reg;

    console_result_t pending_results [$];
    int  error_count = 0;
    int  results_seen = 0;
    bit  idle_on = 1'b1;

    text_console_teletype #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // 8 ns clock
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // screen model
    // ------------------------------------------------------------------------
    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++) screen_cells[i] = BLANK_CELL;
    endfunction

    // content moves up one row, bottom row blanked
    function automatic void lift_rows();
        for (int i = 0; i < CELL_COUNT - SCREEN_COLS; i++)
            screen_cells[i] = screen_cells[i + SCREEN_COLS];
        for (int i = CELL_COUNT - SCREEN_COLS; i < CELL_COUNT; i++)
            screen_cells[i] = BLANK_CELL;
    endfunction

    // content moves down one row, top row blanked
    function automatic void drop_rows();
        for (int i = CELL_COUNT - 1; i >= SCREEN_COLS; i--)
            screen_cells[i] = screen_cells[i - SCREEN_COLS];
        for (int i = 0; i < SCREEN_COLS; i++) screen_cells[i] = BLANK_CELL;
    endfunction

    function automatic int unsigned cursor_cell();
        int unsigned idx;
        idx = cur_row * SCREEN_COLS + cur_col;
        return (idx < CELL_COUNT) ? idx : CELL_COUNT - 1;
    endfunction

    function automatic void step_cursor();
        cur_col++;
        if (cur_col > SCREEN_COLS - 1) begin
            cur_col = 0;
            cur_row++;
        end
    endfunction

    // scroll while the cursor sits below the last row
    function automatic void settle_cursor();
        while (cur_row > SCREEN_ROWS - 1) begin
            lift_rows();
            cur_row--;
        end
    endfunction

    function automatic console_result_t predict_request(input console_req_t req);
        console_result_t res;
        int unsigned     addr;
        res = '0;
        case (req.kind)
            REQ_WRITE: begin
                if (req.ch == CH_NEWLINE) begin
                    screen_cells[cursor_cell()] = BLANK_CELL;
                    cur_col = 0;
                    cur_row++;
                end else if (req.ch == CH_BACKSPACE) begin
                    // nothing to erase at the origin
                    if (cur_col != 0 || cur_row != 0) begin
                        if (cur_col == 0) begin
                            cur_col = SCREEN_COLS - 1;
                            cur_row--;
                        end else begin
                            cur_col--;
                        end
                        screen_cells[cursor_cell()] = BLANK_CELL;
                    end
                end else if (req.ch != CH_RETURN) begin
                    screen_cells[cursor_cell()] = {color_reg, req.ch};
                    step_cursor();
                end
                settle_cursor();
            end
            REQ_READ: begin
                res.read_char = screen_cells[cursor_cell()][CHAR_W-1:0];
                step_cursor();
                settle_cursor();
            end
            REQ_SCR_UP: begin
                drop_rows();
            end
            REQ_SCR_DN: begin
                lift_rows();
                if (cur_row > 0) cur_row--;
            end
            REQ_CLEAR: begin
                blank_screen();
                cur_col = 0;
                cur_row = 0;
            end
            REQ_SET_POS: begin
                cur_col = req.pos % SCREEN_COLS;
                cur_row = req.pos / SCREEN_COLS;
                if (cur_row > SCREEN_ROWS - 1) cur_row = SCREEN_ROWS - 1;
            end
            default: begin
                res.bad_request = 1'b1;
            end
        endcase
        addr = base_reg + cur_row * SCREEN_COLS + cur_col;
        res.cursor_addr = addr[ADDR_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    function automatic console_req_t random_request();
        console_req_t req;
        int           pick;
        req.kind = REQ_WRITE;
        req.ch   = 8'($urandom_range(0, 255));
        req.pos  = 16'($urandom_range(0, 65535));
        pick = $urandom_range(0, 95);
        if (pick < 60) begin
            req.kind = REQ_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 6)       req.ch = CH_NEWLINE;
            else if (pick < 11) req.ch = CH_BACKSPACE;
            else if (pick < 14) req.ch = CH_RETURN;
        end else if (pick < 75) begin
            req.kind = REQ_READ;
        end else if (pick < 87) begin
            req.kind = REQ_SET_POS;
            // mostly on screen, sometimes far past the last row
            if ($urandom_range(0, 99) < 85)
                req.pos = 16'($urandom_range(0, CELL_COUNT - 1));
        end else if (pick < 89) begin
            req.kind = REQ_SCR_UP;
        end else if (pick < 91) begin
            req.kind = REQ_SCR_DN;
        end else if (pick < 93) begin
            req.kind = REQ_CLEAR;
        end else begin
            req.kind = $urandom_range(0, 1) ? REQ_BAD_HI : REQ_BAD_LO;
        end
        return req;
    endfunction

    // offer one request, wait for its transfer, record the expected result
    task automatic send_request(input console_req_t req, input bit fixed,
                                input console_result_t want);
        console_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.pos, req.ch};
        s_axis_tuser  <= req.kind;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = predict_request(req);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // color then page base, one write per cycle
    task automatic write_settings(input logic [COLOR_W-1:0] color,
                                  input logic [ADDR_W-1:0] base);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TEXT_COLOR;
        i_cfg_wdata <= {6'd0, color};
        @(posedge i_clk);
        color_reg = color;
        i_cfg_index <= CFG_PAGE_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        base_reg = base;
        i_cfg_we <= 1'b0;
    endtask

    initial begin : request_source
        console_req_t  req;
        directed_row_t row;
        int            item_count;
        blank_screen();
        cur_col   = 0;
        cur_row   = 0;
        color_reg = COLOR_RESET;
        base_reg  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under reset settings
        for (int n = 0; n < DIRECTED_COUNT; n++) begin
            row = DIRECTED_ROWS[n];
            req = '{kind: row.kind, ch: row.ch, pos: row.pos};
            send_request(req, row.fixed, '{read_char: row.want_char,
                         cursor_addr: row.want_addr, bad_request: row.want_bad});
        end
        drain_results();

        // random phases: low extremes, high extremes, random settings
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: write_settings(8'h00, 14'd0);
                1: write_settings(8'hFF, 14'(PAGE_MAX));
                default: write_settings(8'($urandom_range(0, 255)),
                                        14'($urandom_range(0, PAGE_MAX)));
            endcase
            item_count = (phase == 2) ? 240 : 230;
            for (int n = 0; n < item_count; n++) begin
                // no idling on either side at the end of the run
                if (phase == 2 && n == 120) idle_on = 1'b0;
                send_request(random_request(), 1'b0, '0);
            end
            drain_results();
        end

        // room for any stray result after a full-screen pass
        repeat (2100) @(posedge i_clk);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------
    function automatic void note_error(input string what, input int want, input int got);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    endfunction

    function automatic void check_result();
        console_result_t want;
        if (pending_results.size() == 0) begin
            note_error("unexpected result transfer, addr", -1, m_axis_tdata[21:8]);
            return;
        end
        want = pending_results.pop_front();
        if (m_axis_tdata[7:0] !== want.read_char)
            note_error("read_char", want.read_char, m_axis_tdata[7:0]);
        if (m_axis_tdata[21:8] !== want.cursor_addr)
            note_error("cursor_addr", want.cursor_addr, m_axis_tdata[21:8]);
        if (m_axis_tuser[0] !== want.bad_request)
            note_error("bad_request", want.bad_request, m_axis_tuser[0]);
    endfunction

    initial begin : result_sink
        int stall_left;
        bit long_hold_done;
        stall_left     = 0;
        long_hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (stall_left != 0)
                stall_left--;
            else if (!long_hold_done && results_seen >= 100) begin
                stall_left     = 64;
                long_hold_done = 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 3);
            m_axis_tready <= i_rst_n && (stall_left == 0);
        end
    end

    // hard limit well past the slowest legal run
    initial begin : watchdog
        #50_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
